// ----- hw/rtl/afc_pkg.sv -----
// Shared types and constants for the ASCII frame checker.
package afc_pkg;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_SIZE = 3'd1;
  localparam logic [2:0] PH_SEQ  = 3'd2;
  localparam logic [2:0] PH_TYPE = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_PAR  = 3'd5;

  localparam logic [2:0] V_ACCEPT    = 3'd0;
  localparam logic [2:0] V_OLD       = 3'd1;
  localparam logic [2:0] V_NACK      = 3'd2;
  localparam logic [2:0] V_CTRL      = 3'd3;
  localparam logic [2:0] V_MALFORMED = 3'd4;

  localparam logic [7:0] START_MARK = 8'h7E;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  localparam logic REG_ACK  = 1'b0;
  localparam logic REG_NACK = 1'b1;

  typedef struct packed {
    logic       is_verdict;
    logic [7:0] payload_byte;
    logic [2:0] verdict;
    logic [9:0] frame_sequence;
    logic [6:0] frame_type;
  } result_t;

  typedef struct packed {
    logic [6:0] ack_type_code;
    logic [6:0] nack_type_code;
  } cfg_t;

endpackage

// ----- hw/rtl/afc_cfg_regs.sv -----
// APB-style configuration registers for the ASCII frame checker.
module afc_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output afc_pkg::cfg_t cfg
);

  logic wr_en;

  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ack_type_code  <= 7'd0;
      cfg.nack_type_code <= 7'd1;
    end else if (wr_en) begin
      case (paddr[2])
        afc_pkg::REG_ACK:  cfg.ack_type_code  <= pwdata[6:0];
        afc_pkg::REG_NACK: cfg.nack_type_code <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      afc_pkg::REG_ACK:  prdata = {25'd0, cfg.ack_type_code};
      afc_pkg::REG_NACK: prdata = {25'd0, cfg.nack_type_code};
      default:           prdata = 32'd0;
    endcase
  end

endmodule

// ----- hw/rtl/afc_parser.sv -----
// Input byte register and frame parsing state for the ASCII frame checker.
module afc_parser #(
  parameter int SEQ_MODULUS = 256
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       rx_byte,
  input  afc_pkg::cfg_t    cfg,
  input  logic             out_free,
  output logic             res_valid,
  output afc_pkg::result_t res
);

  localparam logic [8:0] SEQ_WRAP = 9'(SEQ_MODULUS);

  logic       byte_vld;
  logic [7:0] byte_q;
  logic       proc;

  logic [2:0] phase;
  logic [6:0] position;
  logic [6:0] payload_length;
  logic [9:0] sequence_value;
  logic [6:0] type_value;
  logic [7:0] running_xor;
  logic [9:0] parity_value;
  logic       bad_digit;
  logic [7:0] expected_sequence;

  logic [2:0] phase_next;
  logic [6:0] position_next;
  logic [6:0] payload_length_next;
  logic [9:0] sequence_value_next;
  logic [6:0] type_value_next;
  logic [7:0] running_xor_next;
  logic [9:0] parity_value_next;
  logic       bad_digit_next;
  logic [7:0] expected_sequence_next;

  logic       is_digit;
  logic [3:0] dval;
  logic [6:0] position_inc;
  logic [8:0] exp_inc;

  assign proc     = byte_vld && out_free;
  assign in_stall = byte_vld && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_vld <= 1'b0;
    end else if (!in_stall) begin
      byte_vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte_q <= rx_byte;
    end
  end

  assign is_digit     = (byte_q >= afc_pkg::DIGIT_ZERO) && (byte_q <= afc_pkg::DIGIT_NINE);
  assign dval         = is_digit ? 4'(byte_q - afc_pkg::DIGIT_ZERO) : 4'd0;
  assign position_inc = position + 7'd1;
  assign exp_inc      = {1'b0, expected_sequence} + 9'd1;

  always_comb begin
    phase_next             = phase;
    position_next          = position;
    payload_length_next    = payload_length;
    sequence_value_next    = sequence_value;
    type_value_next        = type_value;
    running_xor_next       = running_xor;
    parity_value_next      = parity_value;
    bad_digit_next         = bad_digit;
    expected_sequence_next = expected_sequence;
    res_valid              = 1'b0;
    res.is_verdict         = 1'b0;
    res.payload_byte       = 8'd0;
    res.verdict            = afc_pkg::V_ACCEPT;
    res.frame_sequence     = sequence_value;
    res.frame_type         = type_value;

    case (phase)
      afc_pkg::PH_HUNT: begin
        if (byte_q == afc_pkg::START_MARK) begin
          phase_next          = afc_pkg::PH_SIZE;
          position_next       = 7'd0;
          payload_length_next = 7'd0;
          sequence_value_next = 10'd0;
          type_value_next     = 7'd0;
          running_xor_next    = 8'd0;
          parity_value_next   = 10'd0;
          bad_digit_next      = 1'b0;
        end
      end
      afc_pkg::PH_SIZE: begin
        running_xor_next    = running_xor ^ byte_q;
        payload_length_next = 7'(10'(payload_length) * 10'd10 + 10'(dval));
        bad_digit_next      = bad_digit || !is_digit;
        if (position_inc >= 7'd2) begin
          position_next = 7'd0;
          phase_next    = afc_pkg::PH_SEQ;
        end else begin
          position_next = position_inc;
        end
      end
      afc_pkg::PH_SEQ: begin
        running_xor_next    = running_xor ^ byte_q;
        sequence_value_next = 10'(14'(sequence_value) * 14'd10 + 14'(dval));
        bad_digit_next      = bad_digit || !is_digit;
        if (position_inc >= 7'd3) begin
          position_next = 7'd0;
          phase_next    = afc_pkg::PH_TYPE;
        end else begin
          position_next = position_inc;
        end
      end
      afc_pkg::PH_TYPE: begin
        if (position == 7'd0 || payload_length != 7'd0) begin
          running_xor_next = running_xor ^ byte_q;
        end
        type_value_next = 7'(10'(type_value) * 10'd10 + 10'(dval));
        bad_digit_next  = bad_digit || !is_digit;
        if (position_inc >= 7'd2) begin
          position_next = 7'd0;
          phase_next    = (payload_length != 7'd0) ? afc_pkg::PH_DATA : afc_pkg::PH_PAR;
        end else begin
          position_next = position_inc;
        end
      end
      afc_pkg::PH_DATA: begin
        if ({1'b0, position} + 8'd1 < {1'b0, payload_length}) begin
          running_xor_next = running_xor ^ byte_q;
        end
        res_valid        = byte_vld;
        res.payload_byte = byte_q;
        if (position_inc >= payload_length) begin
          position_next = 7'd0;
          phase_next    = afc_pkg::PH_PAR;
        end else begin
          position_next = position_inc;
        end
      end
      afc_pkg::PH_PAR: begin
        parity_value_next = 10'(14'(parity_value) * 14'd10 + 14'(dval));
        bad_digit_next    = bad_digit || !is_digit;
        if (position_inc < 7'd3) begin
          position_next = position_inc;
        end else begin
          position_next  = 7'd0;
          phase_next     = afc_pkg::PH_HUNT;
          res_valid      = byte_vld;
          res.is_verdict = 1'b1;
          if (bad_digit_next) begin
            res.verdict = afc_pkg::V_MALFORMED;
          end else if (sequence_value != {2'd0, expected_sequence}) begin
            res.verdict = afc_pkg::V_OLD;
          end else if (parity_value_next != {2'd0, running_xor}) begin
            res.verdict = afc_pkg::V_NACK;
          end else if (type_value == cfg.ack_type_code ||
                       type_value == cfg.nack_type_code) begin
            res.verdict = afc_pkg::V_CTRL;
          end else begin
            res.verdict            = afc_pkg::V_ACCEPT;
            expected_sequence_next = (exp_inc == SEQ_WRAP) ? 8'd0 : exp_inc[7:0];
          end
        end
      end
      default: begin
        phase_next    = afc_pkg::PH_HUNT;
        position_next = 7'd0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= afc_pkg::PH_HUNT;
      position          <= 7'd0;
      payload_length    <= 7'd0;
      sequence_value    <= 10'd0;
      type_value        <= 7'd0;
      running_xor       <= 8'd0;
      parity_value      <= 10'd0;
      bad_digit         <= 1'b0;
      expected_sequence <= 8'd0;
    end else if (proc) begin
      phase             <= phase_next;
      position          <= position_next;
      payload_length    <= payload_length_next;
      sequence_value    <= sequence_value_next;
      type_value        <= type_value_next;
      running_xor       <= running_xor_next;
      parity_value      <= parity_value_next;
      bad_digit         <= bad_digit_next;
      expected_sequence <= expected_sequence_next;
    end
  end

endmodule

// ----- hw/rtl/afc_out_stage.sv -----
// Result register of the ASCII frame checker.
module afc_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             res_valid,
  input  afc_pkg::result_t res,
  output logic             out_free,
  output logic             out_valid,
  input  logic             out_stall,
  output afc_pkg::result_t out_res
);

  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && res_valid) begin
      out_res <= res;
    end
  end

endmodule

// ----- hw/rtl/ascii_frame_checker.sv -----
// Top level of the ASCII frame checker: hunts frames, passes payload, gives verdicts.
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_stall    rx_byte
//   out      source     out_valid / out_stall  is_verdict, payload_byte, verdict,
//                                              frame_sequence, frame_type
//   cfg      sink       APB write/read         ack_type_code, nack_type_code
//
// One byte per cycle sustained while the output is not stalled; a taken byte's result
// passes through the input byte register and then the result register before it leaves.
// Reset is synchronous: hunting for the start marker, expected sequence zero.
// A stalled result holds the result register; the byte behind it then holds in_stall high.
module ascii_frame_checker #(
  parameter int SEQ_MODULUS = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        is_verdict,
  output logic [7:0]  payload_byte,
  output logic [2:0]  verdict,
  output logic [9:0]  frame_sequence,
  output logic [6:0]  frame_type,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  afc_pkg::cfg_t    cfg;
  afc_pkg::result_t res;
  afc_pkg::result_t out_res;
  logic             res_valid;
  logic             out_free;

  afc_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  afc_parser #(
    .SEQ_MODULUS (SEQ_MODULUS)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .cfg       (cfg),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  afc_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .out_free  (out_free),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign is_verdict     = out_res.is_verdict;
  assign payload_byte   = out_res.payload_byte;
  assign verdict        = out_res.verdict;
  assign frame_sequence = out_res.frame_sequence;
  assign frame_type     = out_res.frame_type;

endmodule

// ----- hw/rtl/afc_checker.sv -----
// Port-level assertions for the ASCII frame checker and their bind.
module afc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic       is_verdict,
  input logic [7:0] payload_byte,
  input logic [2:0] verdict
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("out transaction dropped while stalled");

  a_payload_verdict_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_verdict |-> verdict == afc_pkg::V_ACCEPT)
    else $error("payload transaction carries a verdict");

  a_verdict_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_verdict |-> payload_byte == 8'd0)
    else $error("verdict transaction carries a payload byte");

  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> verdict <= afc_pkg::V_MALFORMED)
    else $error("verdict code out of range");

  a_out_after_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result without an accepted input transaction");

endmodule

bind ascii_frame_checker afc_checker u_afc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .is_verdict   (is_verdict),
  .payload_byte (payload_byte),
  .verdict      (verdict)
);
